[hdl/pgp_packet_deframer_defines.svh]
// Assertion macros for the deframer RTL, used by pgp_hdr_decode.
`ifndef PGP_PACKET_DEFRAMER_DEFINES_SVH
`define PGP_PACKET_DEFRAMER_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define PGP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define PGP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pgp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pgp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TAG   = 3'd0,
        PH_NLEN1 = 3'd1,
        PH_NLEN2 = 3'd2,
        PH_MULTI = 3'd3,
        PH_DATA  = 3'd4
    } pgp_phase_t;

    // Kind of result reported per byte
    typedef enum logic [1:0] {
        EV_HDR_BYTE = 2'd0,
        EV_HDR_DONE = 2'd1,
        EV_PAYLOAD  = 2'd2
    } pgp_event_t;

    // Old-format length type codes
    typedef enum logic [1:0] {
        OLD_LT_ONE  = 2'd0,
        OLD_LT_TWO  = 2'd1,
        OLD_LT_FOUR = 2'd2,
        OLD_LT_NONE = 2'd3
    } pgp_old_len_t;

    // New-format first length byte boundaries
    localparam logic [7:0]  LEN_TWO_BYTE    = 8'd192;
    localparam logic [7:0]  LEN_UNSUP       = 8'd224;
    localparam logic [7:0]  LEN_FOUR_BYTE   = 8'd255;
    localparam logic [31:0] LEN_TWO_OFFSET  = 32'd192;
    localparam logic [31:0] LEN_UNSUPPORTED = 32'hFFFF_FFFF;

    // One result as it leaves the decoder
    typedef struct packed {
        pgp_event_t         event_kind;
        logic [5:0]         packet_type;
        logic               new_format;
        logic signed [31:0] packet_length;
        logic               header_valid;
        logic [7:0]         payload_byte;
        logic               payload_last;
    } pgp_result_t;

endpackage

`default_nettype wire

[hdl/pgp_interfaces.sv]
`timescale 1ns / 1ps
`default_nettype none

// Raw byte stream channel
interface pgp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Deframer result channel
interface pgp_event_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [5:0]         packet_type;
    logic               new_format;
    logic signed [31:0] packet_length;
    logic               header_valid;
    logic [7:0]         payload_byte;
    logic               payload_last;

    modport source (
        output valid, output event_kind, output packet_type, output new_format,
        output packet_length, output header_valid, output payload_byte,
        output payload_last, input ready
    );
    modport sink (
        input valid, input event_kind, input packet_type, input new_format,
        input packet_length, input header_valid, input payload_byte,
        input payload_last, output ready
    );
endinterface

`default_nettype wire

[hdl/pgp_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input register: holds one byte until the decoder takes it.
module pgp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       valid,
    input  wire logic [7:0] in_byte,
    output logic            ready,
    input  wire logic       advance,
    output logic            hold_valid,
    output logic [7:0]      hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Free slot, or the held byte moves on this cycle
    assign ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (valid && ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            byte_reg <= in_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

`default_nettype wire

[hdl/pgp_hdr_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "pgp_packet_deframer_defines.svh"

// Header state machine: one byte per advance, result formed combinationally.
module pgp_hdr_decode (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [7:0]  in_byte,
    output pgp_pkg::pgp_result_t result
);

    import pgp_pkg::*;

    pgp_phase_t  phase_reg,   phase_next;
    logic        format_reg,  format_next;
    logic [5:0]  type_reg,    type_next;
    logic [2:0]  left_reg,    left_next;
    logic [31:0] accum_reg,   accum_next;
    logic [30:0] payload_reg, payload_next;

    logic        done;
    logic [31:0] done_len;
    logic        hdr_ok;
    logic        last;
    pgp_event_t  kind;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG;
            format_reg  <= 1'b0;
            type_reg    <= '0;
            left_reg    <= '0;
            accum_reg   <= '0;
            payload_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            format_reg  <= format_next;
            type_reg    <= type_next;
            left_reg    <= left_next;
            accum_reg   <= accum_next;
            payload_reg <= payload_next;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        format_next  = format_reg;
        type_next    = type_reg;
        left_next    = left_reg;
        accum_next   = accum_reg;
        payload_next = payload_reg;
        done         = 1'b0;
        done_len     = '0;
        hdr_ok       = 1'b0;
        last         = 1'b0;
        kind         = EV_HDR_BYTE;

        case (phase_reg)
            PH_NLEN1:
            begin
                if (in_byte < LEN_TWO_BYTE)
                begin
                    done     = 1'b1;
                    done_len = {24'd0, in_byte};
                end
                else if (in_byte < LEN_UNSUP)
                begin
                    // 192..223: high part is the low five bits
                    accum_next = {19'd0, in_byte[4:0], 8'd0};
                    phase_next = PH_NLEN2;
                end
                else if (in_byte == LEN_FOUR_BYTE)
                begin
                    accum_next = '0;
                    left_next  = 3'd4;
                    phase_next = PH_MULTI;
                end
                else
                begin
                    done     = 1'b1;
                    done_len = LEN_UNSUPPORTED;
                end
            end
            PH_NLEN2:
            begin
                done     = 1'b1;
                done_len = accum_reg + {24'd0, in_byte} + LEN_TWO_OFFSET;
            end
            PH_MULTI:
            begin
                accum_next = {accum_reg[23:0], in_byte};
                left_next  = left_reg - 3'd1;
                if (left_next == 3'd0)
                begin
                    done     = 1'b1;
                    done_len = {accum_reg[23:0], in_byte};
                end
            end
            PH_DATA:
            begin
                kind = EV_PAYLOAD;
                last = (payload_reg <= 31'd1);
                if (last)
                begin
                    payload_next = '0;
                    phase_next   = PH_TAG;
                end
                else
                begin
                    payload_next = payload_reg - 31'd1;
                end
            end
            default:
            begin
                // Tag byte
                accum_next = '0;
                if (in_byte[6])
                begin
                    format_next = 1'b1;
                    type_next   = in_byte[5:0];
                    phase_next  = PH_NLEN1;
                end
                else
                begin
                    format_next = 1'b0;
                    type_next   = {2'b00, in_byte[5:2]};
                    case (pgp_old_len_t'(in_byte[1:0]))
                        OLD_LT_ONE:  left_next = 3'd1;
                        OLD_LT_TWO:  left_next = 3'd2;
                        OLD_LT_FOUR: left_next = 3'd4;
                        default:     left_next = left_reg;
                    endcase
                    if (pgp_old_len_t'(in_byte[1:0]) == OLD_LT_NONE)
                    begin
                        done     = 1'b1;
                        done_len = LEN_UNSUPPORTED;
                    end
                    else
                    begin
                        phase_next = PH_MULTI;
                    end
                end
            end
        endcase

        // Header completion
        if (done)
        begin
            hdr_ok       = (done_len != 32'd0) && !done_len[31];
            kind         = EV_HDR_DONE;
            accum_next   = done_len;
            left_next    = '0;
            payload_next = hdr_ok ? done_len[30:0] : 31'd0;
            phase_next   = hdr_ok ? PH_DATA : PH_TAG;
        end

        result.event_kind    = kind;
        result.packet_type   = type_next;
        result.new_format    = format_next;
        result.packet_length = (kind == EV_HDR_BYTE) ? 32'sd0 :
                               done ? $signed(done_len) : $signed(accum_reg);
        result.header_valid  = done ? hdr_ok : (kind == EV_PAYLOAD);
        result.payload_byte  = (kind == EV_PAYLOAD) ? in_byte : 8'd0;
        result.payload_last  = last;
    end

    `PGP_ASSERT_NEXT(a_valid_hdr_to_data, clk, rst_n,
        advance && done && hdr_ok, phase_reg == PH_DATA,
        "valid header did not enter payload phase")
    `PGP_ASSERT_SAME(a_data_has_bytes, clk, rst_n,
        phase_reg == PH_DATA, payload_reg != 31'd0,
        "payload phase with no bytes left")
    `PGP_ASSERT_SAME(a_multi_count, clk, rst_n,
        phase_reg == PH_MULTI, (left_reg != 3'd0) && (left_reg <= 3'd4),
        "length byte count out of range")

endmodule

`default_nettype wire

[hdl/pgp_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none

// Result register: decides when the decoder may take the next byte.
module pgp_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    input  wire pgp_pkg::pgp_result_t item,
    output logic                     advance,
    output logic                     valid,
    input  wire logic                ready,
    output pgp_pkg::pgp_result_t     result
);

    import pgp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    pgp_result_t result_reg;

    // Register empty or being drained
    assign advance = item_valid && (!valid_reg || ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= item;
        end
    end

    assign valid  = valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[hdl/pgp_packet_deframer.sv]
// OpenPGP packet deframer: one result per input byte.
// Each byte passes through the input register, the decoder and the result register before its result is offered.
// Throughput: one byte per cycle while the result side does not stall; the header state updates once per byte.
// Reset (rst_n, asynchronous, active low): both stages empty, parser expects a tag byte.
`timescale 1ns / 1ps
`default_nettype none

module pgp_packet_deframer (
    input  wire logic         clk,
    input  wire logic         rst_n,
    pgp_byte_if.sink          byte_chan,
    pgp_event_if.source       event_chan
);

    import pgp_pkg::*;

    logic        advance;
    logic        hold_valid;
    logic [7:0]  hold_byte;
    pgp_result_t dec_result;
    pgp_result_t out_result;

    pgp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (byte_chan.valid),
        .in_byte    (byte_chan.in_byte),
        .ready      (byte_chan.ready),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    pgp_hdr_decode u_dec (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_byte (hold_byte),
        .result  (dec_result)
    );

    pgp_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (hold_valid),
        .item       (dec_result),
        .advance    (advance),
        .valid      (event_chan.valid),
        .ready      (event_chan.ready),
        .result     (out_result)
    );

    // Result fields onto the channel
    assign event_chan.event_kind    = out_result.event_kind;
    assign event_chan.packet_type   = out_result.packet_type;
    assign event_chan.new_format    = out_result.new_format;
    assign event_chan.packet_length = out_result.packet_length;
    assign event_chan.header_valid  = out_result.header_valid;
    assign event_chan.payload_byte  = out_result.payload_byte;
    assign event_chan.payload_last  = out_result.payload_last;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import pgp_pkg::*;

    // Longest two-byte new-format length: first byte 223, second byte 255
    localparam logic [31:0] MAX_TWO_BYTE_LEN = 32'd8383;
    // Two-byte first bytes above this would open payloads of over a thousand bytes
    localparam logic [7:0]  LONG_TWO_BYTE_START = 8'd195;
    localparam int unsigned RANDOM_ITEMS  = 130;
    localparam int unsigned SECTION_ITEMS = 25;

    // Tracks the deframer state and holds the events still to come out
    class pgp_event_tracker;
        pgp_result_t awaited_events[$];
        pgp_phase_t  phase;
        logic        fmt_new;
        logic [5:0]  ptype;
        logic [2:0]  len_bytes_left;
        logic [31:0] len_acc;
        logic [30:0] data_left;
        int unsigned errors;
        int unsigned checked;
        int unsigned headers_done;
        int unsigned headers_good;
        int unsigned payload_bytes;

        function new();
            phase          = PH_TAG;
            fmt_new        = 1'b0;
            ptype          = '0;
            len_bytes_left = '0;
            len_acc        = '0;
            data_left      = '0;
            errors         = 0;
            checked        = 0;
            headers_done   = 0;
            headers_good   = 0;
            payload_bytes  = 0;
        endfunction

        function int unsigned pending();
            return awaited_events.size();
        endfunction

        function bit at_tag();
            return phase == PH_TAG;
        endfunction

        // True where this byte would announce a payload too long for the run
        function bit opens_long_packet(logic [7:0] b);
            if (phase == PH_TAG)
                return !b[6] && (b[1:0] == OLD_LT_TWO || b[1:0] == OLD_LT_FOUR);
            if (phase == PH_NLEN1)
                return (b > LONG_TWO_BYTE_START && b < LEN_UNSUP) || b == LEN_FOUR_BYTE;
            return 1'b0;
        endfunction

        function pgp_result_t make_event(pgp_event_t kind, logic [31:0] len, logic ok,
                                         logic [7:0] pbyte, logic plast);
            pgp_result_t r;
            r.event_kind    = kind;
            r.packet_type   = ptype;
            r.new_format    = fmt_new;
            r.packet_length = len;
            r.header_valid  = ok;
            r.payload_byte  = pbyte;
            r.payload_last  = plast;
            return r;
        endfunction

        // Header finished: a positive length opens the payload, anything else goes back to tag
        function pgp_result_t close_header(logic [31:0] len);
            logic ok;
            ok             = (len != 32'd0) && !len[31];
            len_acc        = len;
            len_bytes_left = '0;
            headers_done++;
            if (ok)
            begin
                headers_good++;
                data_left = len[30:0];
                phase     = PH_DATA;
            end
            else
            begin
                data_left = '0;
                phase     = PH_TAG;
            end
            return make_event(EV_HDR_DONE, len, ok, 8'h00, 1'b0);
        endfunction

        function pgp_result_t decode_byte(logic [7:0] b);
            pgp_result_t  r;
            pgp_old_len_t lt;
            logic         last_one;
            case (phase)
                PH_NLEN1:
                begin
                    if (b < LEN_TWO_BYTE)
                        r = close_header({24'd0, b});
                    else if (b < LEN_UNSUP)
                    begin
                        len_acc = ({24'd0, b} - LEN_TWO_OFFSET) << 8;
                        phase   = PH_NLEN2;
                        r       = make_event(EV_HDR_BYTE, '0, 1'b0, 8'h00, 1'b0);
                    end
                    else if (b == LEN_FOUR_BYTE)
                    begin
                        len_acc        = '0;
                        len_bytes_left = 3'd4;
                        phase          = PH_MULTI;
                        r              = make_event(EV_HDR_BYTE, '0, 1'b0, 8'h00, 1'b0);
                    end
                    else
                        r = close_header(LEN_UNSUPPORTED);
                end
                PH_NLEN2:
                    r = close_header(len_acc + {24'd0, b} + LEN_TWO_OFFSET);
                PH_MULTI:
                begin
                    len_acc        = {len_acc[23:0], b};
                    len_bytes_left = len_bytes_left - 3'd1;
                    if (len_bytes_left == 3'd0)
                        r = close_header(len_acc);
                    else
                        r = make_event(EV_HDR_BYTE, '0, 1'b0, 8'h00, 1'b0);
                end
                PH_DATA:
                begin
                    last_one = (data_left <= 31'd1);
                    r = make_event(EV_PAYLOAD, len_acc, 1'b1, b, last_one);
                    payload_bytes++;
                    if (last_one)
                    begin
                        data_left = '0;
                        phase     = PH_TAG;
                    end
                    else
                        data_left = data_left - 31'd1;
                end
                default:
                begin
                    // Tag byte; bit 7 is not looked at
                    len_acc = '0;
                    if (b[6])
                    begin
                        fmt_new = 1'b1;
                        ptype   = b[5:0];
                        phase   = PH_NLEN1;
                        r       = make_event(EV_HDR_BYTE, '0, 1'b0, 8'h00, 1'b0);
                    end
                    else
                    begin
                        fmt_new = 1'b0;
                        ptype   = {2'b00, b[5:2]};
                        lt      = pgp_old_len_t'(b[1:0]);
                        if (lt == OLD_LT_NONE)
                            r = close_header(LEN_UNSUPPORTED);
                        else
                        begin
                            case (lt)
                                OLD_LT_ONE: len_bytes_left = 3'd1;
                                OLD_LT_TWO: len_bytes_left = 3'd2;
                                default:    len_bytes_left = 3'd4;
                            endcase
                            phase = PH_MULTI;
                            r     = make_event(EV_HDR_BYTE, '0, 1'b0, 8'h00, 1'b0);
                        end
                    end
                end
            endcase
            return r;
        endfunction

        function void note_byte(logic [7:0] b);
            awaited_events = {awaited_events, decode_byte(b)};
        endfunction

        function bit same(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch on event %0d, expected %h, actual %h",
                         $time, field, checked, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_event(pgp_result_t got);
            pgp_result_t want;
            bit          ok;
            if (awaited_events.size() == 0)
            begin
                $display("%0t: event with nothing awaited, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = awaited_events.pop_front();
            ok   = 1'b1;
            ok  &= same("event_kind", want.event_kind, got.event_kind);
            ok  &= same("packet_type", want.packet_type, got.packet_type);
            ok  &= same("new_format", want.new_format, got.new_format);
            ok  &= same("packet_length", want.packet_length, got.packet_length);
            ok  &= same("header_valid", want.header_valid, got.header_valid);
            ok  &= same("payload_byte", want.payload_byte, got.payload_byte);
            ok  &= same("payload_last", want.payload_last, got.payload_last);
            if (!ok)
                errors++;
            checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pgp_byte_if  byte_chan ();
    pgp_event_if event_chan ();

    pgp_packet_deframer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_chan  (byte_chan),
        .event_chan (event_chan)
    );

    pgp_event_tracker tracker = new();

    int unsigned bytes_sent   = 0;
    int unsigned src_gap_pct  = 0;
    int unsigned sink_gap_pct = 0;

    // Clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: random stall bursts
    initial
    begin
        int unsigned stall_left;
        stall_left       = 0;
        event_chan.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && sink_gap_pct != 0 && $urandom_range(99, 0) < sink_gap_pct)
                stall_left = $urandom_range(15, 1);
            if (stall_left != 0)
            begin
                event_chan.ready <= 1'b0;
                stall_left--;
            end
            else
                event_chan.ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && event_chan.valid === 1'b1 && event_chan.ready === 1'b1)
            tracker.check_event({event_chan.event_kind, event_chan.packet_type,
                                 event_chan.new_format, event_chan.packet_length,
                                 event_chan.header_valid, event_chan.payload_byte,
                                 event_chan.payload_last});
    end

    // One request on the byte channel, with an optional gap in front
    task automatic send_byte(input logic [7:0] b);
        if (src_gap_pct != 0 && $urandom_range(99, 0) < src_gap_pct)
        begin
            byte_chan.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clk);
        end
        byte_chan.valid   <= 1'b1;
        byte_chan.in_byte <= b;
        @(posedge clk);
        while (byte_chan.ready !== 1'b1)
            @(posedge clk);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    // Hold the sender until every awaited event has come out
    task automatic drain_results();
        byte_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    function automatic logic [7:0] safe_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (tracker.opens_long_packet(b))
            b = 8'($urandom);
        return b;
    endfunction

    // Feed random bytes until the parser is back at a tag
    task automatic finish_packet();
        while (!tracker.at_tag())
            send_byte(safe_byte());
    endtask

    // Well-formed header for a given length, encoding picked at random
    task automatic send_header(input bit newf, input logic [31:0] len);
        logic [7:0]  hdr[$];
        logic [7:0]  tag;
        logic [31:0] rem;
        bit          short_form;
        short_form = ($urandom_range(3, 0) != 0);
        tag        = 8'($urandom);
        if ($urandom_range(7, 0) != 0)
            tag[7] = 1'b1;
        tag[6] = newf;
        if (newf)
        begin
            hdr = {hdr, tag};
            if (len < LEN_TWO_OFFSET && short_form)
                hdr = {hdr, len[7:0]};
            else if (len >= LEN_TWO_OFFSET && len <= MAX_TWO_BYTE_LEN && short_form)
            begin
                rem = len - LEN_TWO_OFFSET;
                hdr = {hdr, 8'(LEN_TWO_BYTE + rem[15:8])};
                hdr = {hdr, rem[7:0]};
            end
            else
            begin
                hdr = {hdr, LEN_FOUR_BYTE};
                hdr = {hdr, len[31:24]};
                hdr = {hdr, len[23:16]};
                hdr = {hdr, len[15:8]};
                hdr = {hdr, len[7:0]};
            end
        end
        else
        begin
            if (len < 32'd256 && short_form)
            begin
                tag[1:0] = OLD_LT_ONE;
                hdr = {hdr, tag};
            end
            else if (len < 32'd65536 && short_form)
            begin
                tag[1:0] = OLD_LT_TWO;
                hdr = {hdr, tag};
                hdr = {hdr, len[15:8]};
            end
            else
            begin
                tag[1:0] = OLD_LT_FOUR;
                hdr = {hdr, tag};
                hdr = {hdr, len[31:24]};
                hdr = {hdr, len[23:16]};
                hdr = {hdr, len[15:8]};
            end
            hdr = {hdr, len[7:0]};
        end
        foreach (hdr[i])
            send_byte(hdr[i]);
    endtask

    // Unsupported encodings and negative four-byte lengths
    task automatic send_bad_header();
        logic [7:0] tag;
        tag    = 8'($urandom);
        tag[7] = ($urandom_range(7, 0) != 0);
        case ($urandom_range(2, 0))
            0:
            begin
                tag[6] = 1'b1;
                send_byte(tag);
                send_byte(8'($urandom_range(LEN_FOUR_BYTE - 1, LEN_UNSUP)));
            end
            1:
            begin
                tag[6]   = 1'b0;
                tag[1:0] = OLD_LT_NONE;
                send_byte(tag);
            end
            default:
                send_header(1'($urandom_range(1, 0)), {1'b1, 31'($urandom)});
        endcase
    endtask

    // Stimulus
    initial
    begin
        logic [7:0]  opening [24];
        logic [31:0] len;
        int unsigned pick;
        int unsigned section;

        rst_n             = 1'b0;
        byte_chan.valid   = 1'b0;
        byte_chan.in_byte = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length, one-byte payload with tag bit 7 clear, both unsupported extremes,
        // old type 3 with and without bit 7, negative four-byte length, old zero length,
        // old two-byte length with a short payload
        opening = '{8'hFF, 8'h00,
                    8'h40, 8'h01, 8'h00,
                    8'hC1, 8'hE0,
                    8'hD5, 8'hFE,
                    8'hBF,
                    8'h03,
                    8'hCA, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00,
                    8'h84, 8'h00,
                    8'h85, 8'h00, 8'h02, 8'hA5, 8'h5A};
        src_gap_pct  = 15;
        sink_gap_pct = 15;
        foreach (opening[i])
            send_byte(opening[i]);
        drain_results();

        // Random packets, idling changes from section to section
        section = 0;
        while (bytes_sent < RANDOM_ITEMS)
        begin
            if (bytes_sent / SECTION_ITEMS != section)
            begin
                section = bytes_sent / SECTION_ITEMS;
                drain_results();
            end
            case (section % 5)
                0:       begin src_gap_pct = 20; sink_gap_pct = 0;  end
                1:       begin src_gap_pct = 0;  sink_gap_pct = 25; end
                2:       begin src_gap_pct = 0;  sink_gap_pct = 0;  end
                3:       begin src_gap_pct = 35; sink_gap_pct = 35; end
                default: begin src_gap_pct = 8;  sink_gap_pct = 8;  end
            endcase
            pick = $urandom_range(99, 0);
            if (pick < 85)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 12)
                    len = 32'd0;
                else if (pick < 85)
                    len = $urandom_range(8, 1);
                else if (pick < 97)
                    len = $urandom_range(40, 9);
                else
                    len = $urandom_range(300, 41);
                send_header(1'($urandom_range(1, 0)), len);
            end
            else if (pick < 93)
                send_bad_header();
            else
                repeat ($urandom_range(3, 1)) send_byte(safe_byte());
            finish_packet();
        end
        drain_results();

        // Closing stretch at full rate: longest one-byte and shortest two-byte lengths,
        // then a large four-byte length that is left open
        src_gap_pct  = 0;
        sink_gap_pct = 0;
        send_byte(8'hCC);
        send_byte(8'd191);
        finish_packet();
        send_byte(8'hCB);
        send_byte(8'd192);
        send_byte(8'd0);
        finish_packet();
        send_byte({2'b11, 6'($urandom)});
        send_byte(LEN_FOUR_BYTE);
        send_byte({1'b0, 7'($urandom_range(127, 1))});
        repeat (3) send_byte(8'($urandom));
        repeat (20) send_byte(8'($urandom));

        drain_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes, checked %0d events with idling on both sides.",
                 bytes_sent, tracker.checked);
        $display("Decoded %0d headers (%0d opened a payload), %0d payload bytes passed.",
                 tracker.headers_done, tracker.headers_good, tracker.payload_bytes);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
